[design/sitc_pkg.sv]
// Package: shared constants, types and control structs of the interval table block.
package sitc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int RANGE_DEPTH = 64;
  localparam int TIME_BITS   = 64;
  localparam int IO_TIME_W   = 64;
  localparam int IDX_OUT_W   = 8;

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RIDX_W = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int RCNT_W = $clog2(RANGE_DEPTH + 1);

  // cells per group in the registered pick trees
  localparam int TGRP = 16;
  localparam int RGRP = 8;

  typedef logic signed [TIME_BITS-1:0] tm_t;

  localparam tm_t TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    K_INS  = 2'd0,
    K_FIND = 2'd1,
    K_OVL  = 2'd2,
    K_CLR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_NF    = 3'd3,
    ST_RFULL = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [IO_TIME_W-1:0]  start_time;
    logic signed [IO_TIME_W-1:0]  end_time;
  } in_req_t;

  typedef struct packed {
    status_t                      status;
    logic [IDX_OUT_W-1:0]         entry_index;
    logic signed [IO_TIME_W-1:0]  region_start;
    logic signed [IO_TIME_W-1:0]  region_end;
  } out_rsp_t;

  typedef struct packed {
    logic cmp;
    logic wr;
    logic clr;
    tm_t  key_s;
    tm_t  key_e;
  } tt_ctl_t;

  typedef struct packed {
    logic              full;
    logic              dup;
    logic              hit;
    logic [TIDX_W-1:0] hidx;
  } tt_stat_t;

  typedef struct packed {
    logic              cmp;
    logic              load;
    logic              drop;
    logic              inc;
    logic              clr;
    logic [RIDX_W-1:0] lo;
    logic [RIDX_W-1:0] hi;
    logic [RIDX_W-1:0] m;
    logic              m_valid;
    tm_t               bs;
    tm_t               be;
    tm_t               ld_s;
    tm_t               ld_e;
  } rs_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [RIDX_W-1:0] hidx;
    tm_t               hs;
    tm_t               he;
    logic              ha;
    logic              hb;
    logic              full;
    logic [RIDX_W-1:0] tail;
    logic              ov;
    tm_t               os;
    tm_t               oe;
  } rs_stat_t;

endpackage

[design/sitc_tcell.sv]
// Interval table cell: one sorted entry, its compare flags and the shift-up path.
module sitc_tcell (
  input  logic           clk,
  input  logic           cmp_en,
  input  logic           occ,
  input  sitc_pkg::tm_t  key_s,
  input  sitc_pkg::tm_t  key_e,
  input  logic           wr_en,
  input  logic           prev_below,
  input  sitc_pkg::tm_t  prev_s,
  input  sitc_pkg::tm_t  prev_e,
  output sitc_pkg::tm_t  start_q,
  output sitc_pkg::tm_t  end_q,
  output logic           below_q,
  output logic           le_q,
  output logic           eq_q,
  output logic           cov_q
);

  sitc_pkg::tm_t start_r, end_r;
  logic below_r, le_r, eq_r, cov_r;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      below_r <= occ && (start_r < key_s);
      le_r    <= occ && !(key_s < start_r);
      eq_r    <= occ && (start_r == key_s);
      cov_r   <= !(end_r < key_s);
    end
    // entries below the key stay, the slot at the key takes it, the rest move up
    if (wr_en && !below_r) begin
      if (prev_below) begin
        start_r <= key_s;
        end_r   <= key_e;
      end else begin
        start_r <= prev_s;
        end_r   <= prev_e;
      end
    end
  end

  assign start_q = start_r;
  assign end_q   = end_r;
  assign below_q = below_r;
  assign le_q    = le_r;
  assign eq_q    = eq_r;
  assign cov_q   = cov_r;

endmodule

[design/sitc_ttable.sv]
// Interval table: row of sorted cells, entry count and registered duplicate/find tree.
module sitc_ttable (
  input  logic                clk,
  input  logic                rst_n,
  input  sitc_pkg::tt_ctl_t   ctl,
  output sitc_pkg::tt_stat_t  stat
);

  localparam int TD = sitc_pkg::TABLE_DEPTH;
  localparam int GS = sitc_pkg::TGRP;
  localparam int NG = (TD + GS - 1) / GS;
  localparam int IW = sitc_pkg::TIDX_W;
  localparam int CW = sitc_pkg::TCNT_W;

  logic [CW-1:0] cnt_r;

  sitc_pkg::tm_t c_s [TD];
  sitc_pkg::tm_t c_e [TD];
  logic c_below [TD];
  logic c_le    [TD];
  logic c_eq    [TD];
  logic c_cov   [TD];
  logic hit     [TD];

  logic          g_dup_r   [NG];
  logic          g_hit_r   [NG];
  logic [IW-1:0] g_idx_r   [NG];
  logic          g_dup_nxt [NG];
  logic          g_hit_nxt [NG];
  logic [IW-1:0] g_idx_nxt [NG];

  generate
    for (genvar i = 0; i < TD; i++) begin : g_cell
      logic          pb;
      sitc_pkg::tm_t ps, pe;
      logic          occ;
      if (i == 0) begin : g_head
        assign pb = 1'b1;
        assign ps = '0;
        assign pe = '0;
      end else begin : g_body
        assign pb = c_below[i-1];
        assign ps = c_s[i-1];
        assign pe = c_e[i-1];
      end
      assign occ = CW'(i) < cnt_r;

      sitc_tcell u_cell (
        .clk        (clk),
        .cmp_en     (ctl.cmp),
        .occ        (occ),
        .key_s      (ctl.key_s),
        .key_e      (ctl.key_e),
        .wr_en      (ctl.wr),
        .prev_below (pb),
        .prev_s     (ps),
        .prev_e     (pe),
        .start_q    (c_s[i]),
        .end_q      (c_e[i]),
        .below_q    (c_below[i]),
        .le_q       (c_le[i]),
        .eq_q       (c_eq[i]),
        .cov_q      (c_cov[i])
      );

      // covering entry: last start not above the key, with its end reaching the key
      if (i == TD - 1) begin : g_last
        assign hit[i] = c_le[i] && c_cov[i];
      end else begin : g_mid
        assign hit[i] = c_le[i] && !c_le[i+1] && c_cov[i];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clr) begin
      cnt_r <= '0;
    end else if (ctl.wr) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // first tree level: one-hot hit encodes by OR within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      g_dup_nxt[g] = 1'b0;
      g_hit_nxt[g] = 1'b0;
      g_idx_nxt[g] = '0;
      for (int l = 0; l < GS; l++) begin
        if (g * GS + l < TD) begin
          g_dup_nxt[g] = g_dup_nxt[g] | c_eq[g*GS+l];
          if (hit[g*GS+l]) begin
            g_hit_nxt[g] = 1'b1;
            g_idx_nxt[g] = g_idx_nxt[g] | IW'(g * GS + l);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      g_dup_r[g] <= g_dup_nxt[g];
      g_hit_r[g] <= g_hit_nxt[g];
      g_idx_r[g] <= g_idx_nxt[g];
    end
  end

  always_comb begin
    stat.full = cnt_r == CW'(TD);
    stat.dup  = 1'b0;
    stat.hit  = 1'b0;
    stat.hidx = '0;
    for (int g = 0; g < NG; g++) begin
      stat.dup  = stat.dup | g_dup_r[g];
      stat.hit  = stat.hit | g_hit_r[g];
      stat.hidx = stat.hidx | (g_hit_r[g] ? g_idx_r[g] : '0);
    end
  end

endmodule

[design/sitc_rcell.sv]
// Range cell: one coalesced range, its abut/overlap flags and the shift-down path.
module sitc_rcell (
  input  logic           clk,
  input  logic           cmp_en,
  input  sitc_pkg::tm_t  bs,
  input  sitc_pkg::tm_t  be,
  input  logic           ld_en,
  input  sitc_pkg::tm_t  ld_s,
  input  sitc_pkg::tm_t  ld_e,
  input  logic           nx_en,
  input  sitc_pkg::tm_t  nx_s,
  input  sitc_pkg::tm_t  nx_e,
  output sitc_pkg::tm_t  start_q,
  output sitc_pkg::tm_t  end_q,
  output logic           a_q,
  output logic           b_q,
  output logic           ov_q
);

  sitc_pkg::tm_t start_r, end_r;
  logic a_r, b_r, ov_r;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      // a: broadcast span runs right into this range; b: this range runs into it
      a_r  <= (be != sitc_pkg::TIME_MAX) && (be + sitc_pkg::tm_t'(1) == start_r);
      b_r  <= (end_r != sitc_pkg::TIME_MAX) && (end_r + sitc_pkg::tm_t'(1) == bs);
      ov_r <= !(end_r < bs) && !(be < start_r);
    end
    if (ld_en) begin
      start_r <= ld_s;
      end_r   <= ld_e;
    end else if (nx_en) begin
      start_r <= nx_s;
      end_r   <= nx_e;
    end
  end

  assign start_q = start_r;
  assign end_q   = end_r;
  assign a_q     = a_r;
  assign b_q     = b_r;
  assign ov_q    = ov_r;

endmodule

[design/sitc_rstore.sv]
// Range store: row of range cells, range count and registered first-abut/last-overlap picks.
module sitc_rstore (
  input  logic                clk,
  input  logic                rst_n,
  input  sitc_pkg::rs_ctl_t   ctl,
  output sitc_pkg::rs_stat_t  stat
);

  localparam int RD = sitc_pkg::RANGE_DEPTH;
  localparam int GS = sitc_pkg::RGRP;
  localparam int NG = (RD + GS - 1) / GS;
  localparam int IW = sitc_pkg::RIDX_W;
  localparam int CW = sitc_pkg::RCNT_W;

  logic [CW-1:0] cnt_r;

  sitc_pkg::tm_t c_s [RD];
  sitc_pkg::tm_t c_e [RD];
  logic c_a  [RD];
  logic c_b  [RD];
  logic c_ov [RD];
  logic hit  [RD];
  logic ovh  [RD];

  logic          h_nxt  [NG];
  logic [IW-1:0] hi_nxt [NG];
  sitc_pkg::tm_t hs_nxt [NG];
  sitc_pkg::tm_t he_nxt [NG];
  logic          ha_nxt [NG];
  logic          hb_nxt [NG];
  logic          o_nxt  [NG];
  sitc_pkg::tm_t os_nxt [NG];
  sitc_pkg::tm_t oe_nxt [NG];

  logic          h_r  [NG];
  logic [IW-1:0] hi_r [NG];
  sitc_pkg::tm_t hs_r [NG];
  sitc_pkg::tm_t he_r [NG];
  logic          ha_r [NG];
  logic          hb_r [NG];
  logic          o_r  [NG];
  sitc_pkg::tm_t os_r [NG];
  sitc_pkg::tm_t oe_r [NG];

  generate
    for (genvar i = 0; i < RD; i++) begin : g_cell
      sitc_pkg::tm_t ns, ne;
      logic ld, nx;
      if (i == RD - 1) begin : g_tail
        assign ns = '0;
        assign ne = '0;
      end else begin : g_body
        assign ns = c_s[i+1];
        assign ne = c_e[i+1];
      end
      assign ld = ctl.load && (IW'(i) == ctl.lo);
      assign nx = ctl.drop && (IW'(i) >= ctl.hi);

      sitc_rcell u_cell (
        .clk     (clk),
        .cmp_en  (ctl.cmp),
        .bs      (ctl.bs),
        .be      (ctl.be),
        .ld_en   (ld),
        .ld_s    (ctl.ld_s),
        .ld_e    (ctl.ld_e),
        .nx_en   (nx),
        .nx_s    (ns),
        .nx_e    (ne),
        .start_q (c_s[i]),
        .end_q   (c_e[i]),
        .a_q     (c_a[i]),
        .b_q     (c_b[i]),
        .ov_q    (c_ov[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clr) begin
      cnt_r <= '0;
    end else if (ctl.inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (ctl.drop) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // the range being merged never pairs with itself
  always_comb begin
    for (int i = 0; i < RD; i++) begin
      hit[i] = (CW'(i) < cnt_r) && (c_a[i] || c_b[i]) &&
               !(ctl.m_valid && (IW'(i) == ctl.m));
      ovh[i] = (CW'(i) < cnt_r) && c_ov[i];
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      h_nxt[g]  = 1'b0;
      hi_nxt[g] = '0;
      hs_nxt[g] = '0;
      he_nxt[g] = '0;
      ha_nxt[g] = 1'b0;
      hb_nxt[g] = 1'b0;
      o_nxt[g]  = 1'b0;
      os_nxt[g] = '0;
      oe_nxt[g] = '0;
      // walk down so the lowest abutting range wins
      for (int l = GS - 1; l >= 0; l--) begin
        if (g * GS + l < RD) begin
          if (hit[g*GS+l]) begin
            h_nxt[g]  = 1'b1;
            hi_nxt[g] = IW'(g * GS + l);
            hs_nxt[g] = c_s[g*GS+l];
            he_nxt[g] = c_e[g*GS+l];
            ha_nxt[g] = c_a[g*GS+l];
            hb_nxt[g] = c_b[g*GS+l];
          end
        end
      end
      // walk up so the highest overlapping range wins
      for (int l = 0; l < GS; l++) begin
        if (g * GS + l < RD) begin
          if (ovh[g*GS+l]) begin
            o_nxt[g]  = 1'b1;
            os_nxt[g] = c_s[g*GS+l];
            oe_nxt[g] = c_e[g*GS+l];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      h_r[g]  <= h_nxt[g];
      hi_r[g] <= hi_nxt[g];
      hs_r[g] <= hs_nxt[g];
      he_r[g] <= he_nxt[g];
      ha_r[g] <= ha_nxt[g];
      hb_r[g] <= hb_nxt[g];
      o_r[g]  <= o_nxt[g];
      os_r[g] <= os_nxt[g];
      oe_r[g] <= oe_nxt[g];
    end
  end

  always_comb begin
    stat.full = cnt_r == CW'(RD);
    stat.tail = IW'(cnt_r);
    stat.hit  = 1'b0;
    stat.hidx = '0;
    stat.hs   = '0;
    stat.he   = '0;
    stat.ha   = 1'b0;
    stat.hb   = 1'b0;
    stat.ov   = 1'b0;
    stat.os   = '0;
    stat.oe   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (h_r[g]) begin
        stat.hit  = 1'b1;
        stat.hidx = hi_r[g];
        stat.hs   = hs_r[g];
        stat.he   = he_r[g];
        stat.ha   = ha_r[g];
        stat.hb   = hb_r[g];
      end
    end
    for (int g = 0; g < NG; g++) begin
      if (o_r[g]) begin
        stat.ov = 1'b1;
        stat.os = os_r[g];
        stat.oe = oe_r[g];
      end
    end
  end

endmodule

[design/sorted_interval_table_with_coalescing.sv]
// Top level: request sequencer over the interval table and the range store.
//
// Use: present a request on in_req with in_valid; it is taken at a clock edge
// where in_valid is high and in_stall is low. in_stall stays high while a
// request is being worked on. Each request produces exactly one response on
// out_rsp, held with out_valid until an edge where out_stall is low.
// Kinds: insert interval, find covering interval, overlap query, clear all.
// Clear goes straight to the finish state; find takes one table pass and
// overlap one range pass; insert takes a table pass, ends there when
// rejected, and else goes on with one range pass plus one more for each
// range the interval extends or merges. Each table pass is a compare in
// every cell plus two levels of the registered pick tree; each range pass is
// the same on the range row, and merging repeats that pass until no range abuts another.
// A new request is taken as soon as the previous one has been handed to the
// output register, so a stalled response does not block the next request;
// only its completion waits for the output register to drain.
// Reset (rst_n low, synchronous) empties both stores by zeroing their counts;
// stored times are not cleared and are never read before being written.
module sorted_interval_table_with_coalescing (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sitc_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output sitc_pkg::out_rsp_t out_rsp
);

  localparam int TB = sitc_pkg::TIME_BITS;
  localparam int OW = sitc_pkg::IO_TIME_W;
  localparam int XW = sitc_pkg::IDX_OUT_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TCMP  = 8'b0000_0010,
    S_TWAIT = 8'b0000_0100,
    S_TDEC  = 8'b0000_1000,
    S_RCMP  = 8'b0001_0000,
    S_RWAIT = 8'b0010_0000,
    S_RDEC  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  sitc_pkg::kind_t kind_r, kind_nxt;
  sitc_pkg::tm_t qs_r, qs_nxt;     // request start, kept for overlap clipping
  sitc_pkg::tm_t qe_r, qe_nxt;
  sitc_pkg::tm_t ms_r, ms_nxt;     // range currently being folded in
  sitc_pkg::tm_t me_r, me_nxt;
  logic [sitc_pkg::RIDX_W-1:0] m_r, m_nxt;
  logic mv_r, mv_nxt;
  sitc_pkg::out_rsp_t res_r, res_nxt;
  sitc_pkg::out_rsp_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  sitc_pkg::tt_ctl_t  tctl;
  sitc_pkg::tt_stat_t tst;
  sitc_pkg::rs_ctl_t  rctl;
  sitc_pkg::rs_stat_t rst;

  logic in_acc, out_free, use_a;
  sitc_pkg::tm_t new_s, new_e, clip_s, clip_e;
  logic [sitc_pkg::RIDX_W-1:0] lo_idx, hi_idx;

  sitc_ttable u_ttable (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tctl),
    .stat  (tst)
  );

  sitc_rstore u_rstore (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .stat  (rst)
  );

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Merge step. The range being merged is the only one that can abut another,
  // so the first pair in scan order is the lowest abutting index. Below the
  // merged range the start-side abut takes priority; above it the end side.
  always_comb begin
    use_a  = rst.ha && (!(mv_r && (rst.hidx > m_r)) || !rst.hb);
    new_s  = use_a ? ms_r : rst.hs;
    new_e  = use_a ? rst.he : me_r;
    lo_idx = (mv_r && (m_r < rst.hidx)) ? m_r : rst.hidx;
    hi_idx = (mv_r && (m_r < rst.hidx)) ? rst.hidx : m_r;
    clip_s = (qs_r < rst.os) ? rst.os : qs_r;
    clip_e = (qe_r < rst.oe) ? qe_r : rst.oe;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    qs_nxt        = qs_r;
    qe_nxt        = qe_r;
    ms_nxt        = ms_r;
    me_nxt        = me_r;
    m_nxt         = m_r;
    mv_nxt        = mv_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    tctl       = '0;
    tctl.key_s = qs_r;
    tctl.key_e = qe_r;
    rctl       = '0;
    rctl.bs      = ms_r;
    rctl.be      = me_r;
    rctl.m       = m_r;
    rctl.m_valid = mv_r;
    rctl.ld_s    = ms_r;
    rctl.ld_e    = me_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_req.kind;
          qs_nxt   = in_req.start_time[TB-1:0];
          qe_nxt   = in_req.end_time[TB-1:0];
          ms_nxt   = in_req.start_time[TB-1:0];
          me_nxt   = in_req.end_time[TB-1:0];
          mv_nxt   = 1'b0;
          res_nxt  = '0;
          case (in_req.kind)
            sitc_pkg::K_INS, sitc_pkg::K_FIND: state_nxt = S_TCMP;
            sitc_pkg::K_OVL:                   state_nxt = S_RCMP;
            default: begin
              tctl.clr  = 1'b1;
              rctl.clr  = 1'b1;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_TCMP: begin
        tctl.cmp  = 1'b1;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        state_nxt = S_TDEC;
      end
      S_TDEC: begin
        if (kind_r == sitc_pkg::K_FIND) begin
          res_nxt.status      = tst.hit ? sitc_pkg::ST_OK : sitc_pkg::ST_NF;
          res_nxt.entry_index = tst.hit ? XW'(tst.hidx) : '0;
          state_nxt           = S_FIN;
        end else if (tst.full) begin
          res_nxt.status = sitc_pkg::ST_FULL;
          state_nxt      = S_FIN;
        end else if (tst.dup) begin
          res_nxt.status = sitc_pkg::ST_DUP;
          state_nxt      = S_FIN;
        end else begin
          // shift the table open and fold the interval into the ranges
          tctl.wr   = 1'b1;
          state_nxt = S_RCMP;
        end
      end
      S_RCMP: begin
        rctl.cmp  = 1'b1;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        state_nxt = S_RDEC;
      end
      S_RDEC: begin
        if (kind_r == sitc_pkg::K_OVL) begin
          res_nxt.status       = rst.ov ? sitc_pkg::ST_OK : sitc_pkg::ST_NF;
          res_nxt.region_start = rst.ov ? OW'(clip_s) : '0;
          res_nxt.region_end   = rst.ov ? OW'(clip_e) : '0;
          state_nxt            = S_FIN;
        end else if (!rst.hit) begin
          if (mv_r) begin
            res_nxt.status = sitc_pkg::ST_OK;
          end else if (rst.full) begin
            res_nxt.status = sitc_pkg::ST_RFULL;
          end else begin
            // append as a new range
            rctl.load      = 1'b1;
            rctl.inc       = 1'b1;
            rctl.lo        = rst.tail;
            res_nxt.status = sitc_pkg::ST_OK;
          end
          state_nxt = S_FIN;
        end else begin
          rctl.load = 1'b1;
          rctl.lo   = lo_idx;
          rctl.ld_s = new_s;
          rctl.ld_e = new_e;
          if (mv_r) begin
            rctl.drop = 1'b1;
            rctl.hi   = hi_idx;
          end
          ms_nxt    = new_s;
          me_nxt    = new_e;
          m_nxt     = lo_idx;
          mv_nxt    = 1'b1;
          state_nxt = S_RCMP;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    qs_r   <= qs_nxt;
    qe_r   <= qe_nxt;
    ms_r   <= ms_nxt;
    me_r   <= me_nxt;
    m_r    <= m_nxt;
    mv_r   <= mv_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // a finished response always lands in the output register once it is free
  a_fin_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished response not handed to output register");

  // the merge pick never selects the range being merged
  a_merge_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDEC && kind_r == sitc_pkg::K_INS && mv_r && rst.hit) |->
      (rst.hidx != m_r))
    else $error("range merged with itself");

  // a clear request finishes without touching the pick trees
  a_clear_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.kind == sitc_pkg::K_CLR) |=> (state_r == S_FIN))
    else $error("clear request did not finish directly");

endmodule

[test/testbench.sv]
// Testbench: self-checking random and directed test of the sorted interval table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int            CYCLE_LIMIT = 3000000;
  localparam sitc_pkg::tm_t TIME_MIN    = {1'b1, {(sitc_pkg::TIME_BITS-1){1'b0}}};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  sitc_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_stall;
  sitc_pkg::out_rsp_t out_rsp;

  sorted_interval_table_with_coalescing u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  // Shadow copy of both stores, updated when a request is accepted.
  sitc_pkg::tm_t iv_s [sitc_pkg::TABLE_DEPTH];
  sitc_pkg::tm_t iv_e [sitc_pkg::TABLE_DEPTH];
  sitc_pkg::tm_t rg_s [sitc_pkg::RANGE_DEPTH];
  sitc_pkg::tm_t rg_e [sitc_pkg::RANGE_DEPTH];
  int  iv_n;
  int  rg_n;

  sitc_pkg::out_rsp_t pending_rsp[$];
  int       errors;
  int       hold_left;   // long receiver hold-off, counted down by the stall process
  bit       quiet;       // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung block.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- interval table predictor ----------------

  // A span ending at e is directly followed by s; the largest time abuts nothing.
  function automatic bit abuts(sitc_pkg::tm_t e, sitc_pkg::tm_t s);
    return (e != sitc_pkg::TIME_MAX) && (e + 64'sd1 == s);
  endfunction

  function automatic void drop_range(int j);
    for (int k = j; k + 1 < rg_n; k++) begin
      rg_s[k] = rg_s[k+1];
      rg_e[k] = rg_e[k+1];
    end
    if (rg_n > 0) rg_n--;
  endfunction

  // Merge abutting range pairs until none are left.
  function automatic void merge_ranges();
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      for (int i = 0; i < rg_n && !again; i++) begin
        for (int j = i + 1; j < rg_n && !again; j++) begin
          if (abuts(rg_e[j], rg_s[i])) begin
            rg_s[i] = rg_s[j];
            drop_range(j);
            again = 1'b1;
          end else if (abuts(rg_e[i], rg_s[j])) begin
            rg_e[i] = rg_e[j];
            drop_range(j);
            again = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic sitc_pkg::status_t coalesce(sitc_pkg::tm_t s, sitc_pkg::tm_t e);
    for (int i = 0; i < rg_n; i++) begin
      if (abuts(e, rg_s[i])) begin
        rg_s[i] = s;
        merge_ranges();
        return sitc_pkg::ST_OK;
      end
      if (abuts(rg_e[i], s)) begin
        rg_e[i] = e;
        merge_ranges();
        return sitc_pkg::ST_OK;
      end
    end
    if (rg_n >= sitc_pkg::RANGE_DEPTH) return sitc_pkg::ST_RFULL;
    rg_s[rg_n] = s;
    rg_e[rg_n] = e;
    rg_n++;
    return sitc_pkg::ST_OK;
  endfunction

  // Count of stored starts below key, or not above key when incl is set.
  function automatic int starts_below(sitc_pkg::tm_t key, bit incl);
    int lo, hi, mid;
    bit up;
    lo = 0;
    hi = iv_n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      up  = incl ? !(key < iv_s[mid]) : (iv_s[mid] < key);
      if (up) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic sitc_pkg::out_rsp_t interval_table_step(sitc_pkg::in_req_t r);
    sitc_pkg::out_rsp_t o;
    sitc_pkg::tm_t      s, e;
    int                 pos;
    o = '0;
    s = r.start_time;
    e = r.end_time;
    case (r.kind)
      sitc_pkg::K_INS: begin
        if (iv_n >= sitc_pkg::TABLE_DEPTH) begin
          o.status = sitc_pkg::ST_FULL;
        end else begin
          pos = starts_below(s, 1'b0);
          if (pos < iv_n && iv_s[pos] == s) begin
            o.status = sitc_pkg::ST_DUP;
          end else begin
            for (int k = iv_n; k > pos; k--) begin
              iv_s[k] = iv_s[k-1];
              iv_e[k] = iv_e[k-1];
            end
            iv_s[pos] = s;
            iv_e[pos] = e;
            iv_n++;
            o.status = coalesce(s, e);
          end
        end
      end
      sitc_pkg::K_FIND: begin
        pos = starts_below(s, 1'b1);
        o.status = sitc_pkg::ST_NF;
        if (pos > 0 && !(iv_e[pos-1] < s)) begin
          o.status      = sitc_pkg::ST_OK;
          o.entry_index = sitc_pkg::IDX_OUT_W'(pos - 1);
        end
      end
      sitc_pkg::K_OVL: begin
        o.status = sitc_pkg::ST_NF;
        // the last range that meets the span wins
        for (int i = 0; i < rg_n; i++) begin
          if (!(rg_e[i] < s) && !(e < rg_s[i])) begin
            o.status       = sitc_pkg::ST_OK;
            o.region_start = (s < rg_s[i]) ? rg_s[i] : s;
            o.region_end   = (e < rg_e[i]) ? e : rg_e[i];
          end
        end
      end
      default: begin
        iv_n = 0;
        rg_n = 0;
        o.status = sitc_pkg::ST_OK;
      end
    endcase
    return o;
  endfunction

  // ---------------- driving and checking ----------------

  // Offer one request after a random gap; predict its response once it is taken.
  task automatic send(sitc_pkg::kind_t k, sitc_pkg::tm_t s, sitc_pkg::tm_t e);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.kind       = k;
    in_req.start_time = s;
    in_req.end_time   = e;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(interval_table_step(in_req));
  endtask

  // Drop valid and hold until every response is back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // Compare every accepted response with the oldest prediction.
  always @(posedge clk) begin
    sitc_pkg::out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.status != want.status)
          report_mismatch("status", out_rsp.status, want.status);
        if (out_rsp.entry_index != want.entry_index)
          report_mismatch("entry_index", out_rsp.entry_index, want.entry_index);
        if (out_rsp.region_start != want.region_start)
          report_mismatch("region_start", out_rsp.region_start, want.region_start);
        if (out_rsp.region_end != want.region_end)
          report_mismatch("region_end", out_rsp.region_end, want.region_end);
      end
    end
  end

  // Receiver stall: random gaps, or a long hold-off when one is requested.
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (left > 0) begin
        out_stall = 1'b1;
        left--;
      end else begin
        out_stall = 1'b0;
        left = pick_gap();
      end
    end
  end

  // ---------------- tests ----------------

  // Hand-picked cases: misses, abutting merges, duplicates, extremes, reversed spans.
  task automatic test_directed();
    send(sitc_pkg::K_FIND, 64'sd5, 64'sd0);            // empty table
    send(sitc_pkg::K_OVL, TIME_MIN, sitc_pkg::TIME_MAX); // empty range store
    send(sitc_pkg::K_INS, 64'sd10, 64'sd19);
    send(sitc_pkg::K_INS, 64'sd20, 64'sd29);           // extend range end
    send(sitc_pkg::K_INS, 64'sd0, 64'sd9);             // extend range start
    send(sitc_pkg::K_INS, 64'sd10, 64'sd12);           // duplicate start
    send(sitc_pkg::K_INS, 64'sd41, 64'sd49);
    send(sitc_pkg::K_INS, 64'sd30, 64'sd40);           // bridge two ranges, forcing a merge
    send(sitc_pkg::K_FIND, 64'sd15, -64'sd1);
    send(sitc_pkg::K_FIND, -64'sd100, 64'sd0);         // below all starts
    send(sitc_pkg::K_FIND, 64'sd60, 64'sd0);           // past nearest interval
    send(sitc_pkg::K_OVL, 64'sd12, 64'sd25);
    send(sitc_pkg::K_OVL, 64'sd100, 64'sd200);         // no overlap
    send(sitc_pkg::K_INS, 64'sd80, 64'sd70);           // reversed span
    send(sitc_pkg::K_FIND, 64'sd80, 64'sd0);
    send(sitc_pkg::K_INS, sitc_pkg::TIME_MAX - 64'sd5, sitc_pkg::TIME_MAX);
    send(sitc_pkg::K_INS, sitc_pkg::TIME_MAX, sitc_pkg::TIME_MAX); // largest end abuts nothing
    send(sitc_pkg::K_INS, TIME_MIN, TIME_MIN);
    send(sitc_pkg::K_FIND, sitc_pkg::TIME_MAX, TIME_MIN);
    send(sitc_pkg::K_OVL, TIME_MIN, sitc_pkg::TIME_MAX);
    send(sitc_pkg::K_OVL, sitc_pkg::TIME_MAX, TIME_MIN); // reversed query
    send(sitc_pkg::K_CLR, sitc_pkg::TIME_MAX, TIME_MIN);
    send(sitc_pkg::K_FIND, 64'sd15, 64'sd0);
    send(sitc_pkg::K_OVL, TIME_MIN, sitc_pkg::TIME_MAX);
    drain();
  endtask

  // Fill both stores: spaced intervals never abut, so ranges run out first.
  task automatic test_fill();
    sitc_pkg::tm_t base, s;
    base = $urandom_range(0, 1) ? sitc_pkg::tm_t'({$urandom, $urandom}) : 64'sd0;
    send(sitc_pkg::K_CLR, 64'sd0, 64'sd0);
    for (int i = 0; i < 330; i++) begin
      s = base + sitc_pkg::tm_t'($urandom_range(0, 1023)) * 64'sd4;
      send(sitc_pkg::K_INS, s, s + 64'sd1);
    end
    for (int i = 0; i < 10; i++) begin
      s = base + sitc_pkg::tm_t'($urandom_range(0, 4095));
      send($urandom_range(0, 1) ? sitc_pkg::K_FIND : sitc_pkg::K_OVL, s, s + 64'sd20);
    end
    drain();
  endtask

  // Mostly tight windows so starts collide and intervals abut; some full-width noise.
  task automatic test_random(int n);
    sitc_pkg::tm_t   base, s, e;
    int              r;
    sitc_pkg::kind_t k;
    base = 64'sd0;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        r = $urandom_range(0, 3);
        base = (r == 0) ? sitc_pkg::tm_t'({$urandom, $urandom}) :
               (r == 1) ? sitc_pkg::TIME_MAX - 64'sd400 :
               (r == 2) ? TIME_MIN : -64'sd150;
      end
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      k = (r < 45) ? sitc_pkg::K_INS : (r < 70) ? sitc_pkg::K_FIND :
          (r < 97) ? sitc_pkg::K_OVL : sitc_pkg::K_CLR;
      s = base + sitc_pkg::tm_t'($urandom_range(0, 300));
      r = $urandom_range(0, 99);
      if (r < 75) e = s + sitc_pkg::tm_t'($urandom_range(0, 8));
      else if (r < 85) e = s - sitc_pkg::tm_t'($urandom_range(1, 8));
      else begin
        s = sitc_pkg::tm_t'({$urandom, $urandom});
        e = sitc_pkg::tm_t'({$urandom, $urandom});
      end
      send(k, s, e);
    end
    quiet = 1'b0;
    drain();
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 30; i++)
      send(i % 3 == 0 ? sitc_pkg::K_INS : sitc_pkg::K_FIND,
           sitc_pkg::tm_t'(i * 7), sitc_pkg::tm_t'(i * 7 + 6));
    drain();
  endtask

  initial begin
    errors    = 0;
    hold_left = 0;
    quiet     = 1'b0;
    iv_n      = 0;
    rg_n      = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_stall = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_fill();
    test_random(700);

    repeat (300) @(negedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/sitc_pkg.sv
design/sitc_tcell.sv
design/sitc_ttable.sv
design/sitc_rcell.sv
design/sitc_rstore.sv
design/sorted_interval_table_with_coalescing.sv
test/testbench.sv
